@@ hdl/imudr_pkg.sv @@
// shared constants, command codes and helpers for the dead-reckoning integrator
package imudr_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_ENTRIES = 24;
    localparam int ROT_STEPS    = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;
    localparam int STEP_W       = $clog2(ATAN_ENTRIES);

    localparam int MUL_A_W = 36;
    localparam int MUL_B_W = 34;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    localparam logic signed [MUL_B_W-1:0] GAIN_Q30 = 34'sd652032874;
    localparam logic signed [MUL_B_W-1:0] PI_Q30   = 34'sd3373259426;
    localparam logic signed [MUL_B_W-1:0] BAM_K    = 34'sd42722830;

    localparam logic [3:0] OP_NOP  = 4'd0;
    localparam logic [3:0] OP_LOAD = 4'd1;
    localparam logic [3:0] OP_DVX  = 4'd2;
    localparam logic [3:0] OP_DVY  = 4'd3;
    localparam logic [3:0] OP_ZMUL = 4'd4;
    localparam logic [3:0] OP_ROT  = 4'd5;
    localparam logic [3:0] OP_QUAD = 4'd6;
    localparam logic [3:0] OP_WX0  = 4'd7;
    localparam logic [3:0] OP_WX1  = 4'd8;
    localparam logic [3:0] OP_WY0  = 4'd9;
    localparam logic [3:0] OP_WY1  = 4'd10;
    localparam logic [3:0] OP_PX   = 4'd11;
    localparam logic [3:0] OP_PY   = 4'd12;
    localparam logic [3:0] OP_H0   = 4'd13;
    localparam logic [3:0] OP_H1   = 4'd14;
    localparam logic [3:0] OP_OUT  = 4'd15;

    typedef struct packed {
        logic [3:0]        op;
        logic [STEP_W-1:0] step;
    } t_cmd;

    function automatic logic signed [MUL_B_W-1:0] atan_q30(input logic [STEP_W-1:0] i);
        logic signed [MUL_B_W-1:0] v;
        unique case (i)
            5'd0:  v = 34'sh03243F6A8;
            5'd1:  v = 34'sh01DAC6705;
            5'd2:  v = 34'sh00FADBAFC;
            5'd3:  v = 34'sh007F56EA6;
            5'd4:  v = 34'sh003FEAB76;
            5'd5:  v = 34'sh001FFD55B;
            5'd6:  v = 34'sh000FFFAAA;
            5'd7:  v = 34'sh0007FFF55;
            5'd8:  v = 34'sh0003FFFEA;
            5'd9:  v = 34'sh0001FFFFD;
            5'd10: v = 34'sh0000FFFFF;
            5'd11: v = 34'sh00007FFFF;
            5'd12: v = 34'sh00003FFFF;
            5'd13: v = 34'sh00001FFFF;
            5'd14: v = 34'sh00000FFFF;
            5'd15: v = 34'sh000007FFF;
            5'd16: v = 34'sh000003FFF;
            5'd17: v = 34'sh000001FFF;
            5'd18: v = 34'sh000000FFF;
            5'd19: v = 34'sh0000007FF;
            5'd20: v = 34'sh0000003FF;
            5'd21: v = 34'sh0000001FF;
            5'd22: v = 34'sh0000000FF;
            5'd23: v = 34'sh00000007F;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
        logic signed [31:0] r;
        if (v > 38'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -38'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

@@ hdl/imudr_ctrl.sv @@
// sequencing state machine: handshakes and datapath commands
module imudr_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output imudr_pkg::t_cmd      o_cmd
);
    import imudr_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DVX  = 4'd1;
    localparam logic [3:0] S_DVY  = 4'd2;
    localparam logic [3:0] S_ZMUL = 4'd3;
    localparam logic [3:0] S_ROT  = 4'd4;
    localparam logic [3:0] S_QUAD = 4'd5;
    localparam logic [3:0] S_WX0  = 4'd6;
    localparam logic [3:0] S_WX1  = 4'd7;
    localparam logic [3:0] S_WY0  = 4'd8;
    localparam logic [3:0] S_WY1  = 4'd9;
    localparam logic [3:0] S_PX   = 4'd10;
    localparam logic [3:0] S_PY   = 4'd11;
    localparam logic [3:0] S_H0   = 4'd12;
    localparam logic [3:0] S_H1   = 4'd13;
    localparam logic [3:0] S_OUT  = 4'd14;

    logic [3:0]        r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_out_valid, n_out_valid;
    logic              out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd.op    = OP_NOP;
        o_cmd.step  = r_step;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_DVX;
                end
            end
            S_DVX: begin
                o_cmd.op = OP_DVX;
                n_state  = S_DVY;
            end
            S_DVY: begin
                o_cmd.op = OP_DVY;
                n_state  = S_ZMUL;
            end
            S_ZMUL: begin
                o_cmd.op = OP_ZMUL;
                n_step   = '0;
                n_state  = S_ROT;
            end
            S_ROT: begin
                o_cmd.op = OP_ROT;
                n_step   = r_step + 1'b1;
                if (r_step == STEP_W'(ROT_STEPS - 1)) begin
                    n_state = S_QUAD;
                end
            end
            S_QUAD: begin
                o_cmd.op = OP_QUAD;
                n_state  = S_WX0;
            end
            S_WX0: begin
                o_cmd.op = OP_WX0;
                n_state  = S_WX1;
            end
            S_WX1: begin
                o_cmd.op = OP_WX1;
                n_state  = S_WY0;
            end
            S_WY0: begin
                o_cmd.op = OP_WY0;
                n_state  = S_WY1;
            end
            S_WY1: begin
                o_cmd.op = OP_WY1;
                n_state  = S_PX;
            end
            S_PX: begin
                o_cmd.op = OP_PX;
                n_state  = S_PY;
            end
            S_PY: begin
                o_cmd.op = OP_PY;
                n_state  = S_H0;
            end
            S_H0: begin
                o_cmd.op = OP_H0;
                n_state  = S_H1;
            end
            S_H1: begin
                o_cmd.op = OP_H1;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    o_cmd.op    = OP_OUT;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

@@ hdl/imudr_datapath.sv @@
// integrator state, shared multiplier, cordic unit and output registers
module imudr_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  imudr_pkg::t_cmd      i_cmd,
    input  logic signed [15:0]   i_accel_x,
    input  logic signed [15:0]   i_accel_y,
    input  logic signed [15:0]   i_yaw_rate,
    input  logic        [15:0]   i_interval,
    output logic signed [31:0]   o_pos_x,
    output logic signed [31:0]   o_pos_y,
    output logic        [15:0]   o_heading,
    output logic signed [31:0]   o_vel_x,
    output logic signed [31:0]   o_vel_y,
    output logic signed [15:0]   o_turn_rate
);
    import imudr_pkg::*;

    logic signed [15:0] r_ax, r_ay, r_w;
    logic        [15:0] r_dt;
    logic signed [15:0] r_lax, r_lay;
    logic signed [31:0] r_vx, r_vy, r_px, r_py;
    logic        [15:0] r_h;
    logic signed [MUL_B_W-1:0] r_cx, r_sy, r_z;
    logic signed [PROD_W-1:0]  r_acc;
    logic signed [35:0]        r_wx, r_wy;

    logic signed [17:0]        diff_x, diff_y;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b, dt_b, xs, ys, atan_v;
    logic signed [PROD_W-1:0]  prod, rnd11, rnd15, rnd16, rnd40, wsum_x, wsum_y;
    logic signed [PROD_W-1:0]  rnd_wx, rnd_wy;

    assign diff_x = 18'(r_ax) + 18'(r_ax) + 18'(r_ax) - 18'(r_lax);
    assign diff_y = 18'(r_ay) + 18'(r_ay) + 18'(r_ay) - 18'(r_lay);
    assign dt_b   = MUL_B_W'($signed({1'b0, r_dt}));

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (i_cmd.op)
            OP_DVX:  begin mul_a = MUL_A_W'(diff_x); mul_b = dt_b; end
            OP_DVY:  begin mul_a = MUL_A_W'(diff_y); mul_b = dt_b; end
            OP_ZMUL: begin
                mul_a = MUL_A_W'($signed({1'b0, r_h[13:0]}));
                mul_b = PI_Q30;
            end
            OP_WX0:  begin mul_a = MUL_A_W'(r_vx); mul_b = r_cx; end
            OP_WX1:  begin mul_a = MUL_A_W'(r_vy); mul_b = r_sy; end
            OP_WY0:  begin mul_a = MUL_A_W'(r_vx); mul_b = r_sy; end
            OP_WY1:  begin mul_a = MUL_A_W'(r_vy); mul_b = r_cx; end
            OP_PX:   begin mul_a = r_wx; mul_b = dt_b; end
            OP_PY:   begin mul_a = r_wy; mul_b = dt_b; end
            OP_H0:   begin mul_a = MUL_A_W'(r_w); mul_b = dt_b; end
            OP_H1:   begin mul_a = MUL_A_W'($signed(r_acc[32:0])); mul_b = BAM_K; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign prod   = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign rnd11  = (prod + (PROD_W'(1) <<< 10)) >>> 11;
    assign rnd15  = (prod + (PROD_W'(1) <<< 14)) >>> 15;
    assign rnd16  = (prod + (PROD_W'(1) <<< 15)) >>> 16;
    assign rnd40  = (prod + (PROD_W'(1) <<< 39)) >>> 40;
    assign wsum_x = r_acc - prod;
    assign wsum_y = r_acc + prod;
    assign rnd_wx = (wsum_x + (PROD_W'(1) <<< 29)) >>> 30;
    assign rnd_wy = (wsum_y + (PROD_W'(1) <<< 29)) >>> 30;

    assign xs     = r_cx >>> i_cmd.step;
    assign ys     = r_sy >>> i_cmd.step;
    assign atan_v = atan_q30(i_cmd.step);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lax <= '0;
            r_lay <= '0;
            r_vx  <= '0;
            r_vy  <= '0;
            r_px  <= '0;
            r_py  <= '0;
            r_h   <= '0;
        end else begin
            unique case (i_cmd.op)
                OP_DVX: begin
                    r_vx  <= sat32(38'(r_vx) + 38'(rnd11));
                    r_lax <= r_ax;
                end
                OP_DVY: begin
                    r_vy  <= sat32(38'(r_vy) + 38'(rnd11));
                    r_lay <= r_ay;
                end
                OP_PX:   r_px <= sat32(38'(r_px) + 38'(rnd16));
                OP_PY:   r_py <= sat32(38'(r_py) + 38'(rnd16));
                OP_H1:   r_h  <= r_h + rnd40[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_LOAD: begin
                r_ax <= i_accel_x;
                r_ay <= i_accel_y;
                r_w  <= i_yaw_rate;
                r_dt <= i_interval;
            end
            OP_ZMUL: begin
                r_z  <= MUL_B_W'(rnd15);
                r_cx <= GAIN_Q30;
                r_sy <= '0;
            end
            OP_ROT: begin
                if (!r_z[MUL_B_W-1]) begin
                    r_cx <= r_cx - ys;
                    r_sy <= r_sy + xs;
                    r_z  <= r_z - atan_v;
                end else begin
                    r_cx <= r_cx + ys;
                    r_sy <= r_sy - xs;
                    r_z  <= r_z + atan_v;
                end
            end
            OP_QUAD: begin
                unique case (r_h[15:14])
                    2'd0: begin r_cx <= r_cx;  r_sy <= r_sy;  end
                    2'd1: begin r_cx <= -r_sy; r_sy <= r_cx;  end
                    2'd2: begin r_cx <= -r_cx; r_sy <= -r_sy; end
                    default: begin r_cx <= r_sy; r_sy <= -r_cx; end
                endcase
            end
            OP_WX0:  r_acc <= prod;
            OP_WX1:  r_wx  <= 36'(rnd_wx);
            OP_WY0:  r_acc <= prod;
            OP_WY1:  r_wy  <= 36'(rnd_wy);
            OP_H0:   r_acc <= prod;
            OP_OUT: begin
                o_pos_x     <= r_px;
                o_pos_y     <= r_py;
                o_heading   <= r_h;
                o_vel_x     <= r_vx;
                o_vel_y     <= r_vy;
                o_turn_rate <= r_w;
            end
            default: ;
        endcase
    end

endmodule

@@ hdl/imu_dead_reckoning_integrator.sv @@
// top level of the planar imu dead-reckoning integrator
// Each accepted sample updates body velocity, world position and heading and
// gives one result: a single shared multiplier is stepped through the
// velocity, rotation, position and heading products, and the sin/cos comes
// from a CORDIC unit doing one rotation per cycle. The next sample is taken
// as soon as the previous one has reached the output register, while that
// result may still be waiting to be taken; the output register is written
// only once the result before it has been taken.
module imu_dead_reckoning_integrator (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic signed [15:0]   i_accel_x,
    input  logic signed [15:0]   i_accel_y,
    input  logic signed [15:0]   i_yaw_rate,
    input  logic        [15:0]   i_interval,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic signed [31:0]   o_pos_x,
    output logic signed [31:0]   o_pos_y,
    output logic        [15:0]   o_heading,
    output logic signed [31:0]   o_vel_x,
    output logic signed [31:0]   o_vel_y,
    output logic signed [15:0]   o_turn_rate
);
    import imudr_pkg::*;

    t_cmd cmd;

    imudr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    imudr_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_accel_x   (i_accel_x),
        .i_accel_y   (i_accel_y),
        .i_yaw_rate  (i_yaw_rate),
        .i_interval  (i_interval),
        .o_pos_x     (o_pos_x),
        .o_pos_y     (o_pos_y),
        .o_heading   (o_heading),
        .o_vel_x     (o_vel_x),
        .o_vel_y     (o_vel_y),
        .o_turn_rate (o_turn_rate)
    );

endmodule

@@ bench/testbench.sv @@
// self-checking bench for the imu dead-reckoning integrator
`timescale 1ns / 1ps

class nav_scoreboard;
    logic signed [15:0] prev_ax, prev_ay;
    logic signed [31:0] vel_x, vel_y, pos_x, pos_y;
    logic [15:0] yaw;
    logic [31:0] pending_px[$], pending_py[$], pending_vx[$], pending_vy[$];
    logic [15:0] pending_hd[$], pending_tr[$];
    int errors;

    function new();
        prev_ax = 0; prev_ay = 0; vel_x = 0; vel_y = 0; pos_x = 0; pos_y = 0;
        yaw = 0; errors = 0;
    endfunction

    static function longint floor_sh(longint v, int s);
        return v >>> s;
    endfunction

    static function longint round_sh(longint v, int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    static function longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    static function void sine_cosine(logic [15:0] ang, output longint c, output longint s);
        longint x, y, z, xs, ys;
        longint atan_tab[24];
        atan_tab = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
                     64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
                     64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
                     64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF,
                     64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
                     64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};
        z = round_sh(longint'(ang[13:0]) * 64'sd3373259426, 15);
        x = 652032874;
        y = 0;
        for (int i = 0; i < imudr_pkg::ROT_STEPS; i++) begin
            xs = floor_sh(x, i);
            ys = floor_sh(y, i);
            if (z >= 0) begin
                x -= ys; y += xs; z -= atan_tab[i];
            end else begin
                x += ys; y -= xs; z += atan_tab[i];
            end
        end
        case (ang[15:14])
            2'd0: begin c = x; s = y; end
            2'd1: begin c = -y; s = x; end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endfunction

    function void note_sample(logic signed [15:0] ax, logic signed [15:0] ay,
                              logic signed [15:0] rate, logic [15:0] dt);
        longint c, s, wx, wy, dh, t;
        t = longint'(dt);
        vel_x = 32'(clamp32(vel_x + round_sh(t * (3 * longint'(ax) - prev_ax), 11)));
        vel_y = 32'(clamp32(vel_y + round_sh(t * (3 * longint'(ay) - prev_ay), 11)));
        prev_ax = ax;
        prev_ay = ay;
        sine_cosine(yaw, c, s);
        wx = round_sh(longint'(vel_x) * c - longint'(vel_y) * s, 30);
        wy = round_sh(longint'(vel_x) * s + longint'(vel_y) * c, 30);
        pos_x = 32'(clamp32(pos_x + round_sh(wx * t, 16)));
        pos_y = 32'(clamp32(pos_y + round_sh(wy * t, 16)));
        dh = round_sh(longint'(rate) * t * 64'sd42722830, 40);
        yaw = yaw + dh[15:0];
        pending_px.push_back(pos_x);
        pending_py.push_back(pos_y);
        pending_hd.push_back(yaw);
        pending_vx.push_back(vel_x);
        pending_vy.push_back(vel_y);
        pending_tr.push_back(rate);
    endfunction

    function void check_one(string name, logic [31:0] exp_v, logic [31:0] got);
        if (exp_v !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, got);
            errors++;
        end
    endfunction

    function void check_result(logic [31:0] px, logic [31:0] py, logic [15:0] hd,
                               logic [31:0] vx, logic [31:0] vy, logic [15:0] tr);
        if (pending_px.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual pos %h %h",
                     $time, px, py);
            errors++;
            return;
        end
        check_one("pos_x", pending_px.pop_front(), px);
        check_one("pos_y", pending_py.pop_front(), py);
        check_one("heading", pending_hd.pop_front(), hd);
        check_one("vel_x", pending_vx.pop_front(), vx);
        check_one("vel_y", pending_vy.pop_front(), vy);
        check_one("turn_rate", pending_tr.pop_front(), tr);
    endfunction
endclass

module testbench;
    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_in_valid = 0;
    logic o_in_ready;
    logic signed [15:0] i_accel_x = 0, i_accel_y = 0, i_yaw_rate = 0;
    logic [15:0] i_interval = 0;
    logic o_out_valid;
    logic i_out_ready = 0;
    logic signed [31:0] o_pos_x, o_pos_y, o_vel_x, o_vel_y;
    logic [15:0] o_heading;
    logic signed [15:0] o_turn_rate;

    nav_scoreboard board = new();
    int send_idle = 0, recv_idle = 0;
    bit hold_recv = 0;
    bit sending_done = 0;

    imu_dead_reckoning_integrator dut (.*);

    always #5 i_clk = ~i_clk;

    task automatic send_sample(logic [15:0] ax, logic [15:0] ay, logic [15:0] rate,
                               logic [15:0] dt);
        while ($urandom_range(99) < send_idle) begin
            i_in_valid <= 0;
            @(posedge i_clk);
        end
        i_in_valid <= 1;
        i_accel_x <= ax;
        i_accel_y <= ay;
        i_yaw_rate <= rate;
        i_interval <= dt;
        do @(posedge i_clk); while (!o_in_ready);
        board.note_sample(ax, ay, rate, dt);
    endtask

    task automatic send_random(int count);
        logic [15:0] ax, ay, r, dt;
        for (int n = 0; n < count; n++) begin
            ax = $urandom;
            ay = $urandom;
            r = $urandom;
            case ($urandom_range(9))
                0: dt = 0;
                1: dt = $urandom;
                2: dt = 16'hFFFF;
                default: dt = $urandom_range(2000);
            endcase
            if ($urandom_range(3) != 0) begin
                ax = $signed(ax) >>> $urandom_range(12, 4);
                ay = $signed(ay) >>> $urandom_range(12, 4);
            end
            send_sample(ax, ay, r, dt);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready)
                board.check_result(o_pos_x, o_pos_y, o_heading, o_vel_x, o_vel_y,
                                   o_turn_rate);
            i_out_ready <= !hold_recv && ($urandom_range(99) >= recv_idle);
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        send_idle = 24;
        recv_idle = 87;
        send_sample(16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF);
        send_sample(16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF);
        send_sample(16'h1234, 16'h4321, 16'h0100, 16'h0000);
        send_sample(16'hFFFF, 16'h0001, 16'h0000, 16'h0001);
        for (int k = 0; k < 12; k++)
            send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF);
        for (int k = 0; k < 8; k++)
            send_sample(16'h0000, 16'h0000, 16'h4000, 16'(16'h4000 + k * 16'h1000));
        send_random(600);
        send_idle = 87;
        recv_idle = 24;
        send_random(500);
        send_idle = 0;
        recv_idle = 0;
        fork
            begin
                hold_recv = 1;
                repeat (400) @(posedge i_clk);
                hold_recv = 0;
            end
            send_random(20);
        join
        send_random(700);
        i_in_valid <= 0;
        sending_done = 1;
    end

    initial begin
        int wait_cycles;
        wait (sending_done);
        wait_cycles = 0;
        while (board.pending_px.size() != 0 && wait_cycles < 100000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (60) @(posedge i_clk);
        if (board.errors == 0 && board.pending_px.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #20ms;
        $display("Test completed with failures");
        $finish;
    end
endmodule
